/* sv/rgbhsv_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
// Depends on nothing; the converter top level refers to it by scoped names.
package rgbhsv_pkg;

  // Width of one color channel and of every result field.
  localparam int CHAN_W     = 8;
  // Full scale of saturation and hue.
  localparam int FULL_SCALE = 255;
  // One quotient bit is resolved in each divider stage.
  localparam int DIV_STEPS  = 8;

  // Hue dividend 255*num < 255*6*255, hue divisor 6*delta <= 1530.
  localparam int HN_W = 19;
  localparam int HD_W = 11;
  // Saturation dividend 255*delta <= 65025, divisor is the maximum channel.
  localparam int SN_W = 16;
  localparam int SD_W = 8;

  // Incoming pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // Outgoing HSV triple.
  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

endpackage

/* sv/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV converter: channel max/min, dividend setup
// and two pipelined restoring dividers. Depends on rgbhsv_pkg.
// Pipeline: 2 setup stages plus one stage per quotient bit of the 8-bit
// dividers.
// Throughput: one pixel per cycle; the whole pipeline holds while a result
// waits under out_stall. Reset clears the valid bits of every stage only.
module rgb_to_hsv_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rgbhsv_pkg::pix_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rgbhsv_pkg::hsv_t    out_data
);

  localparam int CW = rgbhsv_pkg::CHAN_W;
  localparam int NS = rgbhsv_pkg::DIV_STEPS;
  localparam int HN = rgbhsv_pkg::HN_W;
  localparam int HD = rgbhsv_pkg::HD_W;
  localparam int SN = rgbhsv_pkg::SN_W;
  localparam int SD = rgbhsv_pkg::SD_W;

  // The pipeline moves as a whole unless the result register is held.
  logic adv;

  // Stage 1: pixel, maximum and minimum.
  logic             s1_valid_r;
  rgbhsv_pkg::pix_t s1_pix_r;
  logic [CW-1:0]    s1_max_r, s1_min_r;
  logic [CW-1:0]    max_nxt, min_nxt;

  // Divider stages; index 0 is the output of the dividend setup stage.
  logic          dv_valid_r [NS+1];
  logic [HN-1:0] hrem_r     [NS+1];
  logic [HD-1:0] hd_r       [NS+1];
  logic [SN-1:0] srem_r     [NS+1];
  logic [SD-1:0] sd_r       [NS+1];
  logic [CW-1:0] hq_r       [NS+1];
  logic [CW-1:0] sq_r       [NS+1];
  logic [CW-1:0] bright_r   [NS+1];

  // Dividend setup results.
  logic [CW-1:0] delta;
  logic [HD-1:0] d2, d4, d6, num;
  logic [HN-1:0] hn_nxt;
  logic [HD-1:0] hd_nxt;
  logic [SN-1:0] sn_nxt;
  logic [SD-1:0] sd_nxt;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = dv_valid_r[NS];
  assign out_data  = '{hue: hq_r[NS], saturation: sq_r[NS], brightness: bright_r[NS]};

  // Largest and smallest channel of the incoming pixel.
  always_comb begin
    max_nxt = in_data.red;
    min_nxt = in_data.red;
    if (in_data.green > max_nxt) max_nxt = in_data.green;
    if (in_data.blue > max_nxt) max_nxt = in_data.blue;
    if (in_data.green < min_nxt) min_nxt = in_data.green;
    if (in_data.blue < min_nxt) min_nxt = in_data.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r <= in_data;
      s1_max_r <= max_nxt;
      s1_min_r <= min_nxt;
    end
  end

  // Hue numerator by sector: red first, then green, then blue.
  always_comb begin
    delta = s1_max_r - s1_min_r;
    d2    = {2'b00, delta, 1'b0};
    d4    = {1'b0, delta, 2'b00};
    d6    = d2 + d4;
    if (s1_pix_r.red == s1_max_r) begin
      if (s1_pix_r.green >= s1_pix_r.blue) begin
        num = HD'(s1_pix_r.green - s1_pix_r.blue);
      end else begin
        num = d6 - HD'(s1_pix_r.blue - s1_pix_r.green);
      end
    end else if (s1_pix_r.green == s1_max_r) begin
      num = d2 + HD'(s1_pix_r.blue) - HD'(s1_pix_r.red);
    end else begin
      num = d4 + HD'(s1_pix_r.red) - HD'(s1_pix_r.green);
    end
    // Multiply by 255 as a shift and a subtract.
    hn_nxt = {num, 8'b0} - HN'(num);
    sn_nxt = {delta, 8'b0} - SN'(delta);
    // A zero divisor only occurs with a zero dividend; divide by one instead.
    hd_nxt = (delta == '0) ? HD'(1) : d6;
    sd_nxt = (s1_max_r == '0) ? SD'(1) : s1_max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hrem_r[0]   <= hn_nxt;
      hd_r[0]     <= hd_nxt;
      srem_r[0]   <= sn_nxt;
      sd_r[0]     <= sd_nxt;
      hq_r[0]     <= '0;
      sq_r[0]     <= '0;
      bright_r[0] <= s1_max_r;
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int SH = NS - 1 - k;
    logic [HN-1:0] hsub;
    logic [SN-1:0] ssub;
    logic          hbit, sbit;
    logic [HN-1:0] hrem_nxt;
    logic [SN-1:0] srem_nxt;

    // Compare the partial remainder with the shifted divisor.
    always_comb begin
      hsub     = HN'(hd_r[k]) << SH;
      ssub     = SN'(sd_r[k]) << SH;
      hbit     = hrem_r[k] >= hsub;
      sbit     = srem_r[k] >= ssub;
      hrem_nxt = hbit ? hrem_r[k] - hsub : hrem_r[k];
      srem_nxt = sbit ? srem_r[k] - ssub : srem_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hrem_r[k+1]   <= hrem_nxt;
        srem_r[k+1]   <= srem_nxt;
        hd_r[k+1]     <= hd_r[k];
        sd_r[k+1]     <= sd_r[k];
        hq_r[k+1]     <= {hq_r[k][CW-2:0], hbit};
        sq_r[k+1]     <= {sq_r[k][CW-2:0], sbit};
        bright_r[k+1] <= bright_r[k];
      end
    end
  end

  // A black pixel has no saturation and no hue.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == '0 |->
      out_data.saturation == '0 && out_data.hue == '0)
    else $error("black pixel gave nonzero hue or saturation");

  // Finished divisions leave remainders below their divisors.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hrem_r[NS] < HN'(hd_r[NS]) && srem_r[NS] < SN'(sd_r[NS]))
    else $error("divider remainder not reduced");

  // While the pipeline holds, the first stage, the setup stage and the output keep their valid bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r) && $stable(dv_valid_r[0]) && $stable(out_valid))
    else $error("pipeline moved while held");

endmodule

/* sim/tb.sv */
// Self-checking testbench for rgb_to_hsv_converter: directed and random pixels,
// predicted HSV triples compared field by field with the converter's results.
// Depends on rgbhsv_pkg and the converter top level.
`timescale 1ns / 100ps

module tb;

  // Hue sectors in units of one sixth of the color circle.
  localparam int SECTOR_GREEN = 2;
  localparam int SECTOR_BLUE  = 4;
  localparam int SECTOR_COUNT = 6;

  localparam int RANDOM_PIXELS = 500;
  localparam int LONG_HOLD     = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_LIMIT    = 1000;

  // One pending pixel; drain_first holds it back until every result has arrived.
  typedef struct {
    rgbhsv_pkg::pix_t px;
    bit               drain_first;
  } pixel_job_t;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  rgbhsv_pkg::pix_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rgbhsv_pkg::hsv_t out_data;

  pixel_job_t       pixel_queue[$];
  rgbhsv_pkg::hsv_t hsv_expected[$];

  int pixels_sent   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int sender_wait   = 0;
  int receiver_wait = 0;
  int hold_left     = 0;
  int holds_asked   = 0;
  int holds_granted = 0;
  int idle_cycles   = 0;

  rgb_to_hsv_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected HSV triple for one pixel, in exact integer arithmetic.
  function automatic rgbhsv_pkg::hsv_t hsv_of(rgbhsv_pkg::pix_t px);
    int   r, g, b;
    int   peak, low, span, num, hue;
    rgbhsv_pkg::hsv_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    peak = r;
    low  = r;
    if (g > peak) peak = g;
    if (b > peak) peak = b;
    if (g < low) low = g;
    if (b < low) low = b;
    span = peak - low;
    hue  = 0;
    // Ties go to red first, then green.
    if (span != 0) begin
      if (r == peak) begin
        num = g - b;
        if (g < b) num += SECTOR_COUNT * span;
      end else if (g == peak) begin
        num = SECTOR_GREEN * span + (b - r);
      end else begin
        num = SECTOR_BLUE * span + (r - g);
      end
      hue = (rgbhsv_pkg::FULL_SCALE * num) / (SECTOR_COUNT * span);
    end
    res.hue        = hue[7:0];
    res.saturation = '0;
    if (peak != 0) begin
      num = (rgbhsv_pkg::FULL_SCALE * span) / peak;
      res.saturation = num[7:0];
    end
    res.brightness = peak[7:0];
    return res;
  endfunction

  // Random pixel, biased toward grey, tied channels and extreme values.
  function automatic rgbhsv_pkg::pix_t random_pixel();
    rgbhsv_pkg::pix_t px;
    int   mode;
    logic [7:0] shade;
    logic [7:0] corners [4];
    corners = '{8'd0, 8'd1, 8'd254, 8'd255};
    px    = rgbhsv_pkg::pix_t'($urandom);
    shade = 8'($urandom);
    mode  = $urandom_range(0, 9);
    case (mode)
      0: begin
        px = '{shade, shade, shade};
      end
      1: begin
        px.red   = shade;
        px.green = shade;
      end
      2: begin
        if ($urandom_range(0, 1)) px.green = px.blue;
        else px.red = px.blue;
      end
      3: begin
        px.red   = corners[2'($urandom_range(0, 3))];
        px.green = corners[2'($urandom_range(0, 3))];
        px.blue  = corners[2'($urandom_range(0, 3))];
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit drain_first);
    pixel_job_t job;
    job.px          = '{r, g, b};
    job.drain_first = drain_first;
    pixel_queue.push_back(job);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Driver: records every input transfer and offers the next pending pixel.
  always @(posedge clk) begin
    pixel_job_t job;
    bit burst;
    if (!rst_n) begin
      in_valid <= 1'b0;
      sender_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        hsv_expected.push_back(hsv_of(in_data));
        pixels_sent++;
        burst = (pixels_sent >= 100 && pixels_sent < 200) ||
                (pixels_sent >= 300 && pixels_sent < 380);
        sender_wait = burst ? 0 : $urandom_range(0, 4);
      end
      // A stalled pixel stays on the bus unchanged.
      if (!in_valid || !in_stall) begin
        if (sender_wait > 0) begin
          sender_wait--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0 &&
                     !(pixel_queue[0].drain_first && hsv_expected.size() > 0)) begin
          job = pixel_queue.pop_front();
          in_data  <= job.px;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives the receiver's stall.
  always @(posedge clk) begin
    rgbhsv_pkg::hsv_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result hue %0d sat %0d val %0d",
                                    out_data.hue, out_data.saturation,
                                    out_data.brightness));
        end else begin
          want = hsv_expected.pop_front();
          if (out_data.hue !== want.hue)
            report_mismatch($sformatf("result %0d hue %0d, expected %0d",
                                      results_seen, out_data.hue, want.hue));
          if (out_data.saturation !== want.saturation)
            report_mismatch($sformatf("result %0d saturation %0d, expected %0d",
                                      results_seen, out_data.saturation,
                                      want.saturation));
          if (out_data.brightness !== want.brightness)
            report_mismatch($sformatf("result %0d brightness %0d, expected %0d",
                                      results_seen, out_data.brightness,
                                      want.brightness));
        end
        results_seen++;
        receiver_wait = (results_seen >= 300 && results_seen < 380) ? 0 :
                        $urandom_range(0, 4);
      end
      // A requested long hold takes precedence over the per-transfer wait.
      if (hold_left == 0 && holds_granted != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_granted++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (receiver_wait > 0) begin
        receiver_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TIMEOUT after %0d cycles without a transfer", idle_cycles);
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    // Black, white, grey and the primaries.
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    queue_pixel(8'd1,   8'd1,   8'd1,   1'b0);
    queue_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    queue_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    queue_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    // Red maximum with green below blue wraps around the circle.
    queue_pixel(8'd255, 8'd0,   8'd1,   1'b0);
    queue_pixel(8'd255, 8'd254, 8'd255, 1'b0);
    // Ties between the maximal channels.
    queue_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    queue_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    queue_pixel(8'd200, 8'd200, 8'd10,  1'b0);
    // Smallest nonzero spans, near-grey pixels and two mixed colors.
    queue_pixel(8'd1,   8'd0,   8'd0,   1'b0);
    queue_pixel(8'd0,   8'd0,   8'd1,   1'b0);
    queue_pixel(8'd255, 8'd254, 8'd254, 1'b0);
    queue_pixel(8'd254, 8'd255, 8'd254, 1'b0);
    queue_pixel(8'd170, 8'd85,  8'd0,   1'b0);
    queue_pixel(8'd85,  8'd170, 8'd255, 1'b0);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      pixel_job_t job;
      job.px          = random_pixel();
      job.drain_first = (i == 0) || (i == 250);
      pixel_queue.push_back(job);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Hold the receiver off while the sender keeps streaming.
    while (pixels_sent < 120) @(posedge clk);
    holds_asked++;

    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
    while (hsv_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rgbhsv_pkg.sv
sv/rgb_to_hsv_converter.sv
sim/tb.sv
